// File: rtl/sample_ring_spike_filter_top_assert.svh
// Assertion macros used by the checker file.
`ifndef SAMPLE_RING_SPIKE_FILTER_TOP_ASSERT_SVH
`define SAMPLE_RING_SPIKE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/srsf_pkg.sv
package srsf_pkg;

  localparam int DEPTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SPIKE_MIN_FILL  = 3;

  localparam int VAL_W  = 16;
  localparam int AGE_W  = 10;
  localparam int POS_W  = 10;
  localparam int IDX_W  = 3;

  localparam logic [VAL_W-1:0] RANGE_MAX_RST = 16'd1024;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SPIKE_ON = 3'd0,
    REG_RANGE_ON = 3'd1,
    REG_RANGE_MIN = 3'd2,
    REG_RANGE_MAX = 3'd3,
    REG_FALLBACK = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic             mode;
    logic [VAL_W-1:0] sample;
    logic [AGE_W-1:0] age;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             valid_res;
    logic [POS_W-1:0] position;
    logic             spike_fixed;
    logic             range_fixed;
  } out_t;

  typedef struct packed {
    logic             spike_removal_on;
    logic             range_check_on;
    logic [VAL_W-1:0] range_min;
    logic [VAL_W-1:0] range_max;
    logic [VAL_W-1:0] fallback_value;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic add_en;
    logic rd_en;
    logic rd_load;
  } cmd_t;

endpackage

// File: rtl/srsf_cfg.sv
module srsf_cfg
  import srsf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SPIKE_ON:  cfg_d.spike_removal_on = cfg_data_i[0];
        REG_RANGE_ON:  cfg_d.range_check_on   = cfg_data_i[0];
        REG_RANGE_MIN: cfg_d.range_min        = cfg_data_i;
        REG_RANGE_MAX: cfg_d.range_max        = cfg_data_i;
        REG_FALLBACK:  cfg_d.fallback_value   = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spike_removal_on <= 1'b0;
      cfg_q.range_check_on   <= 1'b0;
      cfg_q.range_min        <= '0;
      cfg_q.range_max        <= RANGE_MAX_RST;
      cfg_q.fallback_value   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/srsf_ctrl.sv
module srsf_ctrl
  import srsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_mode_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // The output register is free if empty or being taken at this edge.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.add_en  = accept && (in_mode_i == MODE_ADD);
    cmd_o.rd_en   = accept && (in_mode_i == MODE_READ);
    cmd_o.rd_load = (state_q == ST_READ);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.rd_en) state_d = ST_READ;
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.add_en || cmd_o.rd_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/srsf_dp.sv
module srsf_dp
  import srsf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output out_t out_o
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CW     = (FILL_W > AGE_W) ? FILL_W : AGE_W;
  localparam int CMP_W  = (SAMPLE_BITS > VAL_W) ? SAMPLE_BITS : VAL_W;
  localparam int TH_W   = SAMPLE_BITS + 4;

  logic [SAMPLE_BITS-1:0] store_mem [DEPTH];

  logic [SLOT_W-1:0]      write_slot_q;
  logic [FILL_W-1:0]      fill_q;
  // Newest and second newest samples; the newest reaches memory on the next add.
  logic [SAMPLE_BITS-1:0] newest_q;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   rd_ok_q;
  logic                   rd_top_q;
  out_t                   out_q;

  logic [SAMPLE_BITS-1:0] smp;
  logic [SAMPLE_BITS-1:0] jump;
  logic [SAMPLE_BITS-1:0] step;
  logic [TH_W-1:0]        step_p1;
  logic [TH_W-1:0]        thresh;
  logic                   spike;
  logic [SAMPLE_BITS-1:0] newest_fix;
  logic                   out_of_range;
  logic                   ranged;
  logic [SAMPLE_BITS-1:0] add_val;
  logic [SLOT_W-1:0]      slot_nxt;
  logic [SLOT_W-1:0]      age_s;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   rd_ok;
  logic [SAMPLE_BITS-1:0] rd_val;

  assign smp = SAMPLE_BITS'(in_i.sample);

  // Spike test: |prev - newest| > 5 * (|prev - incoming| + 1).
  assign jump    = (prev_q > newest_q) ? (prev_q - newest_q) : (newest_q - prev_q);
  assign step    = (prev_q > smp) ? (prev_q - smp) : (smp - prev_q);
  assign step_p1 = TH_W'(step) + TH_W'(1);
  assign thresh  = (step_p1 << 2) + step_p1;
  assign spike   = cfg_i.spike_removal_on && (fill_q > FILL_W'(SPIKE_MIN_FILL)) &&
                   (TH_W'(jump) > thresh);
  assign newest_fix = spike ? prev_q : newest_q;

  assign out_of_range = (CMP_W'(smp) > CMP_W'(cfg_i.range_max)) ||
                        (CMP_W'(smp) < CMP_W'(cfg_i.range_min));
  assign ranged       = cfg_i.range_check_on && out_of_range;

  always_comb begin
    if (!ranged) begin
      add_val = smp;
    end else if (fill_q == '0) begin
      add_val = SAMPLE_BITS'(cfg_i.fallback_value);
    end else begin
      add_val = newest_fix;
    end
  end

  assign slot_nxt = (write_slot_q == SLOT_W'(DEPTH - 1)) ? '0 : write_slot_q + SLOT_W'(1);

  // Slot of a given age; the age is below DEPTH whenever the read is valid.
  assign age_s   = SLOT_W'(in_i.age);
  assign rd_addr = (write_slot_q >= age_s) ? (write_slot_q - age_s)
                                           : (write_slot_q + SLOT_W'(DEPTH) - age_s);
  assign rd_ok   = CW'(in_i.age) < CW'(fill_q);

  always_comb begin
    if (!rd_ok_q) begin
      rd_val = '0;
    end else if (rd_top_q) begin
      rd_val = newest_q;
    end else begin
      rd_val = rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      fill_q       <= '0;
    end else if (cmd_i.add_en) begin
      write_slot_q <= slot_nxt;
      if (fill_q != FILL_W'(DEPTH)) fill_q <= fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    // Retire the (possibly fixed) newest sample into its slot.
    if (cmd_i.add_en && (fill_q != '0)) store_mem[write_slot_q] <= newest_fix;
    if (cmd_i.rd_en) rd_data_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      prev_q            <= newest_fix;
      newest_q          <= add_val;
      out_q.value       <= VAL_W'(add_val);
      out_q.valid_res   <= 1'b1;
      out_q.position    <= POS_W'(slot_nxt);
      out_q.spike_fixed <= spike;
      out_q.range_fixed <= ranged;
    end else if (cmd_i.rd_load) begin
      out_q.value       <= VAL_W'(rd_val);
      out_q.valid_res   <= rd_ok_q;
      out_q.position    <= POS_W'(write_slot_q);
      out_q.spike_fixed <= 1'b0;
      out_q.range_fixed <= 1'b0;
    end
    if (cmd_i.rd_en) begin
      rd_ok_q  <= rd_ok;
      rd_top_q <= (in_i.age == '0);
    end
  end

  assign out_o = out_q;

endmodule

// File: rtl/sample_ring_spike_filter_top.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_i  (mode, sample, age)
// out       output     out_valid_o / out_stall_i out_o (value, valid_res, position, flags)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// An add's result is registered at the edge that accepts it.
// A read does a synchronous memory read, then the output load.
// The newest sample lives in a register and is written to the ring on the next add.
// Reset clears the slot pointer and fill count; the ring needs no clearing pass.
// A new item is taken only while no read is pending and the output register is empty or being emptied.
module sample_ring_spike_filter_top
  import srsf_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0] cfg_data_i
);

  cfg_t cfg;
  cmd_t cmd;

  srsf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  srsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  srsf_dp #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .out_o  (out_o)
  );

endmodule

// File: rtl/srsf_checker.sv
`include "sample_ring_spike_filter_top_assert.svh"

module srsf_checker
  import srsf_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  logic add_acc;
  logic rd_acc;
  logic out_wait;
  logic empty_rd;
  logic no_data;

  assign add_acc  = in_valid_i && !in_stall_o && (in_i.mode == MODE_ADD);
  assign rd_acc   = in_valid_i && !in_stall_o && (in_i.mode == MODE_READ);
  assign out_wait = out_valid_o && out_stall_i;
  assign empty_rd = out_valid_o && !out_o.valid_res;
  assign no_data  = (out_o.value == '0) && !out_o.spike_fixed && !out_o.range_fixed;

  `SRSF_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_o), "stalled result moved")
  `SRSF_ASSERT_NEXT(a_add_result, add_acc, out_valid_o && out_o.valid_res, "add gave no result")
  `SRSF_ASSERT_NEXT(a_read_gap, rd_acc, !out_valid_o && in_stall_o, "read result too early")
  `SRSF_ASSERT_NOW(a_read_flags, empty_rd, no_data, "empty read result carries data")

endmodule

bind sample_ring_spike_filter_top srsf_checker u_srsf_checker (.*);
